@@ sv/ucb1r_pkg.sv @@
// Package for the UCB1 arm ranker: sizes, payload structs, cell control types
// and the rank ordering function. Depends on nothing.
package ucb1r_pkg;

  localparam int MAX_ARMS  = 16;
  localparam int ARM_W     = 4;
  localparam int NUM_W     = 5;
  localparam int FRAC_BITS = 16;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F7;

  // Fixed-point widths of the score datapath.
  localparam int LOG_W    = 5 + FRAC_BITS;
  localparam int T_W      = LOG_W + 1;
  localparam int V_W      = T_W + FRAC_BITS;
  localparam int SQ_STEPS = (V_W + 1) / 2;
  localparam int VP_W     = 2 * SQ_STEPS;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int REM_W    = ROOT_W + 2;
  localparam int STEP_W   = 6;
  localparam int PH_W     = $clog2(MAX_ARMS);

  localparam logic CFG_NUM_ARMS = 1'b0;

  typedef struct packed {
    logic               mode;
    logic [3:0]         arm;
    logic signed [31:0] reward_sum;
    logic [23:0]        pull_count;
    logic [31:0]        iteration;
    logic [4:0]         k;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         best_arm;
    logic signed [31:0] score;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [ARM_W-1:0]   arm;
    logic signed [31:0] score;
  } entry_t;

  typedef struct packed {
    logic               load;
    logic               sort;
    logic               phase;
    logic [NUM_W-1:0]   ne;
    logic [ARM_W-1:0]   load_arm;
    logic signed [31:0] load_score;
  } cell_ctrl_t;

  typedef struct packed {
    logic             odd;
    logic             first;
    logic             last;
    logic [ARM_W-1:0] init_arm;
  } cell_pos_t;

  // True when entry a belongs ahead of entry b: arms in use first, by score
  // descending with the lower index winning a tie; unused arms in index order.
  function automatic logic ranks_before(entry_t a, entry_t b, logic [NUM_W-1:0] ne);
    logic ua;
    logic ub;
    ua = {1'b0, a.arm} < ne;
    ub = {1'b0, b.arm} < ne;
    if (ua != ub) return ua;
    if (ua && (a.score != b.score)) return a.score > b.score;
    return a.arm < b.arm;
  endfunction

endpackage

@@ sv/ucb1r_cell.sv @@
// One rank position of the sorting chain: holds an arm and its score and
// trades them with a neighbour in odd-even transposition phases. Uses ucb1r_pkg.
module ucb1r_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  ucb1r_pkg::cell_ctrl_t ctrl,
  input  ucb1r_pkg::cell_pos_t  pos,
  input  ucb1r_pkg::entry_t     left,
  input  ucb1r_pkg::entry_t     right,
  output ucb1r_pkg::entry_t     ent
);

  logic pair_right;
  logic pair_left;
  logic take_right;
  logic take_left;

  assign pair_right = (pos.odd == ctrl.phase) && !pos.last;
  assign pair_left  = (pos.odd != ctrl.phase) && !pos.first;
  assign take_right = pair_right && ucb1r_pkg::ranks_before(right, ent, ctrl.ne);
  assign take_left  = pair_left && ucb1r_pkg::ranks_before(ent, left, ctrl.ne);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.arm   <= pos.init_arm;
      ent.score <= '0;
    end else if (ctrl.load) begin
      if (ent.arm == ctrl.load_arm) ent.score <= ctrl.load_score;
    end else if (ctrl.sort) begin
      if (take_right) ent <= right;
      else if (take_left) ent <= left;
    end
  end

endmodule

@@ sv/ucb1r_score.sv @@
// Sequential UCB1 score unit: normalise, log2 by repeated squaring, ln scale,
// two restoring divisions, digit-by-digit square root, saturating sum. Uses ucb1r_pkg.
module ucb1r_score (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] reward_sum,
  input  logic [23:0]        pull_count,
  input  logic [31:0]        iteration,
  output logic               done,
  output logic signed [31:0] score
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_NORM = 8'b00000010,
    S_LOG  = 8'b00000100,
    S_LN   = 8'b00001000,
    S_DIVT = 8'b00010000,
    S_DIVM = 8'b00100000,
    S_SQRT = 8'b01000000,
    S_SUM  = 8'b10000000
  } sc_state_t;

  sc_state_t state;
  logic                           r_neg;
  logic [31:0]                    r_mag;
  logic [23:0]                    cnt;
  logic [31:0]                    m;
  logic [4:0]                     e;
  logic [30:0]                    y;
  logic [ucb1r_pkg::FRAC_BITS-1:0] frac;
  logic [ucb1r_pkg::T_W-1:0]      t;
  logic [ucb1r_pkg::STEP_W-1:0]   step;
  logic [31:0]                    dvd;
  logic [23:0]                    rem;
  logic [31:0]                    quo;
  logic [ucb1r_pkg::VP_W-1:0]     src;
  logic [ucb1r_pkg::REM_W-1:0]    srem;
  logic [ucb1r_pkg::ROOT_W-1:0]   root;

  logic [61:0]                    ysq_full;
  logic [31:0]                    ysq;
  logic [ucb1r_pkg::LOG_W+31:0]   ln_prod;
  logic [24:0]                    rem_sh;
  logic                           qbit;
  logic [ucb1r_pkg::REM_W-1:0]    srem_sh;
  logic [ucb1r_pkg::REM_W-1:0]    trial;
  logic signed [32:0]             mean;
  logic signed [33:0]             sum;

  assign ysq_full = {31'b0, y} * {31'b0, y};
  assign ysq      = ysq_full[61:30];
  assign ln_prod  = {e, frac} * ucb1r_pkg::LN2_Q32;
  assign rem_sh   = {rem, dvd[31]};
  assign qbit     = rem_sh >= {1'b0, cnt};
  assign srem_sh  = {srem[ucb1r_pkg::REM_W-3:0], src[ucb1r_pkg::VP_W-1 -: 2]};
  assign trial    = {root, 2'b01};
  assign mean     = r_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum      = {mean[32], mean} + $signed({{(34-ucb1r_pkg::ROOT_W){1'b0}}, root});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_SUM);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r_neg <= reward_sum[31];
            r_mag <= reward_sum[31] ? 32'(-reward_sum) : 32'(reward_sum);
            cnt   <= (pull_count == '0) ? 24'd1 : pull_count;
            m     <= (iteration == '0) ? 32'd1 : iteration;
            e     <= 5'd31;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (m[31]) begin
            y     <= m[31:1];
            frac  <= '0;
            step  <= '0;
            state <= S_LOG;
          end else begin
            m <= {m[30:0], 1'b0};
            e <= e - 5'd1;
          end
        end
        S_LOG: begin
          y    <= ysq[31] ? ysq[31:1] : ysq[30:0];
          frac <= {frac[ucb1r_pkg::FRAC_BITS-2:0], ysq[31]};
          step <= step + 1'b1;
          if (step == ucb1r_pkg::STEP_W'(ucb1r_pkg::FRAC_BITS - 1)) state <= S_LN;
        end
        S_LN: begin
          state <= S_DIVT;
          step  <= '0;
          rem   <= '0;
          dvd   <= 32'({ln_prod[ucb1r_pkg::LOG_W+31:32], 1'b0});
        end
        S_DIVT, S_DIVM: begin
          quo <= {quo[30:0], qbit};
          if (step != ucb1r_pkg::STEP_W'(31)) begin
            rem  <= qbit ? 24'(rem_sh - {1'b0, cnt}) : rem_sh[23:0];
            dvd  <= {dvd[30:0], 1'b0};
            step <= step + 1'b1;
          end else begin
            step <= '0;
            if (state == S_DIVT) begin
              t     <= ucb1r_pkg::T_W'({quo[30:0], qbit});
              rem   <= '0;
              dvd   <= r_mag;
              state <= S_DIVM;
            end else begin
              src   <= ucb1r_pkg::VP_W'({t, {ucb1r_pkg::FRAC_BITS{1'b0}}});
              srem  <= '0;
              root  <= '0;
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (srem_sh >= trial) begin
            srem <= srem_sh - trial;
            root <= {root[ucb1r_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            srem <= srem_sh;
            root <= {root[ucb1r_pkg::ROOT_W-2:0], 1'b0};
          end
          src  <= {src[ucb1r_pkg::VP_W-3:0], 2'b00};
          step <= step + 1'b1;
          if (step == ucb1r_pkg::STEP_W'(ucb1r_pkg::SQ_STEPS - 1)) state <= S_SUM;
        end
        S_SUM: begin
          if (sum > 34'sd2147483647) score <= 32'sh7FFFFFFF;
          else if (sum < -34'sd2147483648) score <= 32'sh80000000;
          else score <= sum[31:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/ucb1_top_k_arm_ranker_top.sv @@
// Top level of the UCB1 arm ranker: control sequencer, APB register, chain of
// rank cells and output register. Uses ucb1r_pkg, ucb1r_cell and ucb1r_score.
//
// The block keeps a UCB1 score for each of sixteen arms and the arms ranked by
// score, highest first, ties going to the lower arm index; arms at or above the
// effective num_arms sit at the end of the ranking in index order. An update
// transfer (mode 0) computes sum/count + sqrt(2 ln n / count) in Q16.16 for an
// arm in use and gives one result, the best arm; a query transfer (mode 1) gives
// the top k arms in rank order with last set on the final one. One item is worked
// on at a time. An update runs from acceptance to its result through normalising
// the iteration number one bit a cycle, 16 squaring steps for the logarithm, the
// ln scaling, two 32-step restoring divisions, 19 square-root steps and the
// saturating sum, then the done handover, the load of the new score, 16 odd-even
// transposition phases through the row of rank cells and the transfer into the
// output register. A query gives its ranks one after another, holding while
// out_ready is low. A write of num_arms while idle re-ranks in odd-even phases,
// during which no item is accepted, nor in the cycle of the write itself. The last
// result may wait in the output register while the next item is already accepted.
module ucb1_top_k_arm_ranker_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ucb1r_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ucb1r_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCORE = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_SORT  = 5'b01000,
    ST_EMIT  = 5'b10000
  } top_state_t;

  top_state_t state;
  logic [ucb1r_pkg::NUM_W-1:0] num_arms;
  logic [ucb1r_pkg::NUM_W-1:0] ne;
  logic [ucb1r_pkg::NUM_W-1:0] kk;
  logic [ucb1r_pkg::NUM_W-1:0] kq;
  logic [ucb1r_pkg::ARM_W-1:0] idx;
  logic [ucb1r_pkg::ARM_W-1:0] upd_arm;
  logic [ucb1r_pkg::PH_W-1:0]  phase_cnt;
  logic                        emit_after;
  logic                        in_fire;
  logic                        cfg_wr;
  logic                        emit_fire;
  logic                        emit_last;
  logic                        sc_start;
  logic                        sc_done;
  logic signed [31:0]          sc_score;
  ucb1r_pkg::cell_ctrl_t       ctrl;
  ucb1r_pkg::entry_t           ent [ucb1r_pkg::MAX_ARMS];

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == ucb1r_pkg::CFG_NUM_ARMS);
  // A register write takes precedence, so no transfer is taken in its cycle.
  assign in_ready = (state == ST_IDLE) && !cfg_wr;
  assign in_fire  = in_valid && in_ready;
  assign prdata   = (paddr[2] == ucb1r_pkg::CFG_NUM_ARMS) ? 32'(num_arms) : 32'd0;

  // Effective arm count: zero reads as one, above the row length saturates.
  always_comb begin
    if (num_arms == '0) ne = ucb1r_pkg::NUM_W'(1);
    else if (num_arms > ucb1r_pkg::NUM_W'(ucb1r_pkg::MAX_ARMS))
      ne = ucb1r_pkg::NUM_W'(ucb1r_pkg::MAX_ARMS);
    else ne = num_arms;
  end

  always_comb begin
    kq = (in_data.k == '0) ? ucb1r_pkg::NUM_W'(1) : in_data.k;
    if (kq > ne) kq = ne;
  end

  assign sc_start  = in_fire && !in_data.mode && ({1'b0, in_data.arm} < ne);
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);
  assign emit_last = ({1'b0, idx} + 1'b1) == kk;

  always_comb begin
    ctrl.load       = (state == ST_LOAD);
    ctrl.sort       = (state == ST_SORT);
    ctrl.phase      = phase_cnt[0];
    ctrl.ne         = ne;
    ctrl.load_arm   = upd_arm;
    ctrl.load_score = sc_score;
  end

  ucb1r_score u_score (
    .clk        (clk),
    .rst        (rst),
    .start      (sc_start),
    .reward_sum (in_data.reward_sum),
    .pull_count (in_data.pull_count),
    .iteration  (in_data.iteration),
    .done       (sc_done),
    .score      (sc_score)
  );

  // The row of rank cells; each trades with its neighbour in alternate phases.
  for (genvar i = 0; i < ucb1r_pkg::MAX_ARMS; i++) begin : g_cell
    ucb1r_pkg::cell_pos_t pos;
    ucb1r_pkg::entry_t    left;
    ucb1r_pkg::entry_t    right;
    assign pos.odd      = 1'(i % 2);
    assign pos.first    = (i == 0);
    assign pos.last     = (i == ucb1r_pkg::MAX_ARMS - 1);
    assign pos.init_arm = ucb1r_pkg::ARM_W'(i);
    if (i == 0) begin : g_l0
      assign left = ent[i];
    end else begin : g_l
      assign left = ent[i-1];
    end
    if (i == ucb1r_pkg::MAX_ARMS - 1) begin : g_rn
      assign right = ent[i];
    end else begin : g_r
      assign right = ent[i+1];
    end
    ucb1r_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .pos   (pos),
      .left  (left),
      .right (right),
      .ent   (ent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      num_arms  <= ucb1r_pkg::NUM_W'(16);
      phase_cnt <= '0;
      idx       <= '0;
      kk        <= '0;
      emit_after <= 1'b0;
    end else begin
      if (cfg_wr) num_arms <= pwdata[ucb1r_pkg::NUM_W-1:0];
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          if (cfg_wr) begin
            phase_cnt  <= '0;
            emit_after <= 1'b0;
            state      <= ST_SORT;
          end else if (in_fire) begin
            upd_arm <= in_data.arm;
            if (in_data.mode) begin
              kk    <= kq;
              state <= ST_EMIT;
            end else begin
              kk    <= ucb1r_pkg::NUM_W'(1);
              state <= sc_start ? ST_SCORE : ST_EMIT;
            end
          end
        end
        ST_SCORE: begin
          if (sc_done) state <= ST_LOAD;
        end
        ST_LOAD: begin
          phase_cnt  <= '0;
          emit_after <= 1'b1;
          state      <= ST_SORT;
        end
        ST_SORT: begin
          // A further count write during a re-rank starts the phases again.
          if (cfg_wr && !emit_after) begin
            phase_cnt <= '0;
          end else begin
            phase_cnt <= phase_cnt + 1'b1;
            if (phase_cnt == ucb1r_pkg::PH_W'(ucb1r_pkg::MAX_ARMS - 1))
              state <= emit_after ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            idx <= idx + 1'b1;
            if (emit_last) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.best_arm <= ent[idx].arm;
      out_data.score    <= ent[idx].score;
      out_data.last     <= emit_last;
    end
  end

endmodule

@@ sv/ucb1r_checker.sv @@
// Port-level checker for the UCB1 arm ranker, bound to the top level.
// Uses ucb1r_pkg for the payload types.
module ucb1r_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input ucb1r_pkg::out_item_t out_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 pready
);

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer taken while an item is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_query_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> !in_ready)
    else $error("item released before its last result");

endmodule

bind ucb1_top_k_arm_ranker_top ucb1r_checker u_ucb1r_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pready    (pready)
);
